@@ rtl/core/ppucrp_pkg.sv @@
// Package with the beat types, codes and constants of the video processor register port.
`timescale 1ns / 1ps

package ppucrp_pkg;

    localparam int OAM_DEPTH_DEF = 256;

    localparam logic [2:0] KIND_READ         = 3'd0;
    localparam logic [2:0] KIND_WRITE        = 3'd1;
    localparam logic [2:0] KIND_VBLANK_START = 3'd2;
    localparam logic [2:0] KIND_VBLANK_END   = 3'd3;
    localparam logic [2:0] KIND_SPRITE_HIT   = 3'd4;

    localparam logic [2:0] REG_CONTROL   = 3'd0;
    localparam logic [2:0] REG_MASK      = 3'd1;
    localparam logic [2:0] REG_STATUS    = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
    localparam logic [2:0] REG_OAM_DATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL    = 3'd5;
    localparam logic [2:0] REG_VADDR     = 3'd6;
    localparam logic [2:0] REG_DATA      = 3'd7;

    localparam logic [7:0]  STATUS_RESET  = 8'h10;
    localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
    localparam logic [15:0] STEP_ACROSS   = 16'd1;
    localparam logic [15:0] STEP_DOWN     = 16'd32;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] mem_read_data;
        logic [7:0] mem_read_below;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] mem_address;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic        nmi_request;
        logic [7:0]  control_out;
        logic [7:0]  mask_out;
        logic [2:0]  fine_x_out;
        logic [15:0] temp_address_out;
        logic [15:0] video_address_out;
    } t_out_item;

endpackage

@@ rtl/core/ppucrp_stream_if.sv @@
// Valid/ready channel interface that carries one beat of a given payload type.
`timescale 1ns / 1ps

interface ppucrp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/ppu_cpu_register_port.sv @@
// Top level of the processor-side register port of the video processor.
`timescale 1ns / 1ps

// One beat in, one beat out: each accepted request beat (read, write or video event)
// yields exactly one response beat, and while the response side is not stalled a new
// request can be taken in every cycle, so the sustained rate is one beat per cycle.
// The request is registered, decoded against the register state in one pass, and the
// response is registered. The sprite memory is an array with one write port and one read
// port, read through a register that always holds the entry at the current OAM address;
// per-entry valid bits make it read as zero after reset, so no clearing pass is needed.
module ppu_cpu_register_port #(
    parameter int OAM_DEPTH = ppucrp_pkg::OAM_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ppucrp_stream_if.sink   i_req,
    ppucrp_stream_if.source o_rsp
);
    import ppucrp_pkg::*;

    localparam int IDX_W = $clog2(OAM_DEPTH);

    logic            r_in_vld;
    t_in_item        r_in;
    logic            r_out_vld;
    t_out_item       r_out;
    logic            advance;

    logic [7:0]      r_control;
    logic [7:0]      r_mask;
    logic [7:0]      r_status;
    logic [7:0]      r_oam_ptr;
    logic            r_second;
    logic [2:0]      r_fine_x;
    logic [15:0]     r_temp;
    logic [15:0]     r_vaddr;
    logic [7:0]      r_buffer;

    logic [7:0]      n_control;
    logic [7:0]      n_mask;
    logic [7:0]      n_status;
    logic [7:0]      n_oam_ptr;
    logic            n_second;
    logic [2:0]      n_fine_x;
    logic [15:0]     n_temp;
    logic [15:0]     n_vaddr;
    logic [7:0]      n_buffer;
    t_out_item       n_out;

    logic [7:0]      oam_mem [OAM_DEPTH];
    logic [OAM_DEPTH-1:0] r_oam_written;
    logic [7:0]      r_oam_q;
    logic            r_oam_hit;
    logic            oam_we;
    logic [15:0]     step;

    assign advance     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || advance;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign step   = r_control[2] ? STEP_DOWN : STEP_ACROSS;
    assign oam_we = advance && (r_in.kind == KIND_WRITE) && (r_in.reg_select == REG_OAM_DATA);

    always_comb begin
        n_control = r_control;
        n_mask    = r_mask;
        n_status  = r_status;
        n_oam_ptr = r_oam_ptr;
        n_second  = r_second;
        n_fine_x  = r_fine_x;
        n_temp    = r_temp;
        n_vaddr   = r_vaddr;
        n_buffer  = r_buffer;
        n_out     = '0;

        case (r_in.kind)
            KIND_READ: begin
                case (r_in.reg_select)
                    REG_STATUS: begin
                        n_out.read_data = r_status;
                        n_status        = {1'b0, r_status[6:0]};
                        n_second        = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        n_out.read_data = r_oam_hit ? r_oam_q : 8'h00;
                    end
                    REG_DATA: begin
                        n_out.mem_address = r_vaddr;
                        n_vaddr           = r_vaddr + step;
                        if (r_vaddr[13:0] < PALETTE_BASE) begin
                            n_out.read_data = r_buffer;
                            n_buffer        = r_in.mem_read_data;
                        end else begin
                            n_out.read_data = r_in.mem_read_data;
                            n_buffer        = r_in.mem_read_below;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_WRITE: begin
                case (r_in.reg_select)
                    REG_CONTROL: begin
                        n_control         = r_in.write_data;
                        n_temp            = {r_temp[15:12], r_in.write_data[1:0], r_temp[9:0]};
                        n_out.nmi_request = r_in.write_data[7] && r_status[7];
                    end
                    REG_MASK: begin
                        n_mask = r_in.write_data;
                    end
                    REG_OAM_ADDR: begin
                        n_oam_ptr = r_in.write_data;
                    end
                    REG_OAM_DATA: begin
                        n_oam_ptr = r_oam_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!r_second) begin
                            n_fine_x = r_in.write_data[2:0];
                            n_temp   = {r_temp[15:5], r_in.write_data[7:3]};
                        end else begin
                            n_temp = {r_temp[15], r_in.write_data[2:0], r_temp[11:10],
                                      r_in.write_data[7:3], r_temp[4:0]};
                        end
                        n_second = !r_second;
                    end
                    REG_VADDR: begin
                        if (!r_second) begin
                            n_temp = {r_in.write_data, r_temp[7:0]};
                        end else begin
                            n_temp  = {r_temp[15:8], r_in.write_data};
                            n_vaddr = {r_temp[15:8], r_in.write_data};
                        end
                        n_second = !r_second;
                    end
                    REG_DATA: begin
                        n_out.mem_address    = r_vaddr;
                        n_out.mem_write      = 1'b1;
                        n_out.mem_write_data = r_in.write_data;
                        n_vaddr              = r_vaddr + step;
                    end
                    default: begin
                    end
                endcase
                n_status = {r_status[7:5], r_in.write_data[4:0]};
            end
            KIND_VBLANK_START: begin
                n_status          = {1'b1, r_status[6:0]};
                n_out.nmi_request = r_control[7];
            end
            KIND_VBLANK_END: begin
                n_status = {2'b00, r_status[5:0]};
            end
            KIND_SPRITE_HIT: begin
                n_status = {r_status[7], 1'b1, r_status[5:0]};
            end
            default: begin
            end
        endcase

        n_out.control_out       = n_control;
        n_out.mask_out          = n_mask;
        n_out.fine_x_out        = n_fine_x;
        n_out.temp_address_out  = n_temp;
        n_out.video_address_out = n_vaddr;

        if (!advance) begin
            n_oam_ptr = r_oam_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_control <= '0;
            r_mask    <= '0;
            r_status  <= STATUS_RESET;
            r_oam_ptr <= '0;
            r_second  <= 1'b0;
            r_fine_x  <= '0;
            r_temp    <= '0;
            r_vaddr   <= '0;
            r_buffer  <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_control <= n_control;
                r_mask    <= n_mask;
                r_status  <= n_status;
                r_oam_ptr <= n_oam_ptr;
                r_second  <= n_second;
                r_fine_x  <= n_fine_x;
                r_temp    <= n_temp;
                r_vaddr   <= n_vaddr;
                r_buffer  <= n_buffer;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // The read register follows the next OAM address, so it always shows the current entry.
    always_ff @(posedge i_clk) begin
        if (oam_we) begin
            oam_mem[r_oam_ptr[IDX_W-1:0]] <= r_in.write_data;
        end
        r_oam_q <= oam_mem[n_oam_ptr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oam_written <= '0;
            r_oam_hit     <= 1'b0;
        end else begin
            if (oam_we) begin
                r_oam_written[r_oam_ptr[IDX_W-1:0]] <= 1'b1;
            end
            r_oam_hit <= r_oam_written[n_oam_ptr[IDX_W-1:0]];
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the video processor register port: random and directed beats.
`timescale 1ns / 1ps

module tb_top;
    import ppucrp_pkg::*;

    localparam logic [2:0] KIND_UNKNOWN_LOW  = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN_HIGH = 3'd7;
    localparam int RESET_CYCLES      = 11;
    localparam int BEATS_PER_PHASE   = 150;
    localparam int PHASE_COUNT       = 4;
    localparam int IDLE_PCT_HEAVY    = 53;
    localparam int IDLE_PCT_LIGHT    = 7;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 20;
    localparam int CYCLE_LIMIT       = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ppucrp_stream_if #(.T(t_in_item))  req_if ();
    ppucrp_stream_if #(.T(t_out_item)) rsp_if ();

    ppu_cpu_register_port dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    t_in_item  pending_beats[$];
    t_out_item expected_rsp[$];
    int        beats_queued = 0;
    int        beats_taken  = 0;
    int        error_count  = 0;
    int        cycle_count  = 0;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      long_stall_arm;
    logic      long_stall_done;
    int        long_stall_left;

    logic [7:0]  pred_control;
    logic [7:0]  pred_mask;
    logic [7:0]  pred_status;
    logic [7:0]  pred_oam_addr;
    logic [7:0]  pred_oam [0:OAM_DEPTH_DEF-1];
    logic        pred_latch;
    logic [2:0]  pred_fine_x;
    logic [15:0] pred_temp_addr;
    logic [15:0] pred_vaddr;
    logic [7:0]  pred_read_buf;

    function automatic logic [15:0] vaddr_step();
        return pred_control[2] ? STEP_DOWN : STEP_ACROSS;
    endfunction

    function automatic t_out_item port_response(t_in_item beat);
        t_out_item rsp;
        rsp = '0;
        case (beat.kind)
            KIND_READ: begin
                case (beat.reg_select)
                    REG_STATUS: begin
                        rsp.read_data = pred_status;
                        pred_status[7] = 1'b0;
                        pred_latch = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        rsp.read_data = pred_oam[pred_oam_addr];
                    end
                    REG_DATA: begin
                        rsp.mem_address = pred_vaddr;
                        pred_vaddr = pred_vaddr + vaddr_step();
                        if (rsp.mem_address[13:0] < PALETTE_BASE) begin
                            rsp.read_data = pred_read_buf;
                            pred_read_buf = beat.mem_read_data;
                        end else begin
                            rsp.read_data = beat.mem_read_data;
                            pred_read_buf = beat.mem_read_below;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_WRITE: begin
                case (beat.reg_select)
                    REG_CONTROL: begin
                        pred_control = beat.write_data;
                        pred_temp_addr[11:10] = beat.write_data[1:0];
                        if (beat.write_data[7] && pred_status[7]) begin
                            rsp.nmi_request = 1'b1;
                        end
                    end
                    REG_MASK: pred_mask = beat.write_data;
                    REG_OAM_ADDR: pred_oam_addr = beat.write_data;
                    REG_OAM_DATA: begin
                        pred_oam[pred_oam_addr] = beat.write_data;
                        pred_oam_addr = pred_oam_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!pred_latch) begin
                            pred_fine_x = beat.write_data[2:0];
                            pred_temp_addr[4:0] = beat.write_data[7:3];
                        end else begin
                            pred_temp_addr[14:12] = beat.write_data[2:0];
                            pred_temp_addr[9:5] = beat.write_data[7:3];
                        end
                        pred_latch = ~pred_latch;
                    end
                    REG_VADDR: begin
                        if (!pred_latch) begin
                            pred_temp_addr[15:8] = beat.write_data;
                        end else begin
                            pred_temp_addr[7:0] = beat.write_data;
                            pred_vaddr = pred_temp_addr;
                        end
                        pred_latch = ~pred_latch;
                    end
                    REG_DATA: begin
                        rsp.mem_address = pred_vaddr;
                        rsp.mem_write = 1'b1;
                        rsp.mem_write_data = beat.write_data;
                        pred_vaddr = pred_vaddr + vaddr_step();
                    end
                    default: ;
                endcase
                pred_status[4:0] = beat.write_data[4:0];
            end
            KIND_VBLANK_START: begin
                pred_status[7] = 1'b1;
                if (pred_control[7]) begin
                    rsp.nmi_request = 1'b1;
                end
            end
            KIND_VBLANK_END: pred_status[7:6] = 2'b00;
            KIND_SPRITE_HIT: pred_status[6] = 1'b1;
            default: ;
        endcase
        rsp.control_out = pred_control;
        rsp.mask_out = pred_mask;
        rsp.fine_x_out = pred_fine_x;
        rsp.temp_address_out = pred_temp_addr;
        rsp.video_address_out = pred_vaddr;
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%h, expected 0x%h", name, got, want));
        end
    endtask

    task automatic queue_beat(logic [2:0] kind, logic [2:0] sel, logic [7:0] wd);
        t_in_item beat;
        beat.kind = kind;
        beat.reg_select = sel;
        beat.write_data = wd;
        beat.mem_read_data = 8'($urandom_range(0, 255));
        beat.mem_read_below = 8'($urandom_range(0, 255));
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic queue_random_sequence();
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] oam_base;
        int         n;
        n = $urandom_range(1, 4);
        case ($urandom_range(0, 9))
            0, 1: begin
                hi = 8'($urandom_range(0, 255));
                lo = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) hi[5:1] = 5'b11111;
                if ($urandom_range(0, 1)) lo[7:4] = 4'hF;
                queue_beat(KIND_WRITE, REG_VADDR, hi);
                queue_beat(KIND_WRITE, REG_VADDR, lo);
                for (int i = 0; i < n; i++) begin
                    queue_beat($urandom_range(0, 2) != 0 ? KIND_READ : KIND_WRITE, REG_DATA,
                               8'($urandom_range(0, 255)));
                end
            end
            2: begin
                queue_beat(KIND_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                queue_beat(KIND_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
            end
            3: begin
                oam_base = 8'($urandom_range(0, 255));
                queue_beat(KIND_WRITE, REG_OAM_ADDR, oam_base);
                for (int i = 0; i < n; i++) begin
                    queue_beat(KIND_WRITE, REG_OAM_DATA, 8'($urandom_range(0, 255)));
                end
                for (int i = 0; i < n; i++) begin
                    queue_beat(KIND_WRITE, REG_OAM_ADDR, oam_base + 8'(i));
                    queue_beat(KIND_READ, REG_OAM_DATA, 8'($urandom_range(0, 255)));
                end
            end
            4: queue_beat(KIND_READ, REG_STATUS, 8'($urandom_range(0, 255)));
            5: queue_beat(KIND_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
            6: begin
                case ($urandom_range(0, 2))
                    0: queue_beat(KIND_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
                    1: queue_beat(KIND_WRITE, REG_OAM_ADDR, 8'($urandom_range(0, 255)));
                    default: queue_beat(KIND_WRITE, REG_STATUS, 8'($urandom_range(0, 255)));
                endcase
            end
            7: queue_beat(3'($urandom_range(KIND_VBLANK_START, KIND_SPRITE_HIT)),
                          3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            8: queue_beat(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
            default: begin
                queue_beat(KIND_WRITE, $urandom_range(0, 1) ? REG_VADDR : REG_SCROLL,
                           8'($urandom_range(0, 255)));
                queue_beat(KIND_READ, $urandom_range(0, 1) ? REG_STATUS : REG_DATA,
                           8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial begin
        pred_control = '0;
        pred_mask = '0;
        pred_status = STATUS_RESET;
        pred_oam_addr = '0;
        for (int i = 0; i < OAM_DEPTH_DEF; i++) pred_oam[i] = '0;
        pred_latch = 1'b0;
        pred_fine_x = '0;
        pred_temp_addr = '0;
        pred_vaddr = '0;
        pred_read_buf = '0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_stall_left <= 0;
            long_stall_done <= 1'b0;
        end else if (long_stall_arm && !long_stall_done) begin
            long_stall_left <= LONG_STALL_CYCLES;
            long_stall_done <= 1'b1;
        end else if (long_stall_left != 0) begin
            long_stall_left <= long_stall_left - 1;
        end
    end

    always @(posedge i_clk) begin : drive_req
        logic hold;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            hold = req_if.valid && !req_if.ready;
            if (req_if.valid && req_if.ready) begin
                expected_rsp.push_back(port_response(req_if.data));
                beats_taken <= beats_taken + 1;
            end
            if (!hold) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_if.data <= pending_beats.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_rsp
        t_out_item want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("response beat with no request outstanding");
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("read_data", 16'(rsp_if.data.read_data), 16'(want.read_data));
                    check_field("mem_address", rsp_if.data.mem_address, want.mem_address);
                    check_field("mem_write", 16'(rsp_if.data.mem_write), 16'(want.mem_write));
                    check_field("mem_write_data", 16'(rsp_if.data.mem_write_data),
                                16'(want.mem_write_data));
                    check_field("nmi_request", 16'(rsp_if.data.nmi_request),
                                16'(want.nmi_request));
                    check_field("control_out", 16'(rsp_if.data.control_out),
                                16'(want.control_out));
                    check_field("mask_out", 16'(rsp_if.data.mask_out), 16'(want.mask_out));
                    check_field("fine_x_out", 16'(rsp_if.data.fine_x_out),
                                16'(want.fine_x_out));
                    check_field("temp_address_out", rsp_if.data.temp_address_out,
                                want.temp_address_out);
                    check_field("video_address_out", rsp_if.data.video_address_out,
                                want.video_address_out);
                end
            end
            rsp_if.ready <= (long_stall_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        int phase_goal;
        i_rst_n = 1'b0;
        long_stall_arm = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(KIND_READ, REG_STATUS, 8'h00);
        queue_beat(KIND_READ, REG_CONTROL, 8'hFF);
        queue_beat(KIND_READ, REG_SCROLL, 8'h00);
        queue_beat(KIND_WRITE, REG_VADDR, 8'hFF);
        queue_beat(KIND_WRITE, REG_VADDR, 8'hFF);
        queue_beat(KIND_READ, REG_DATA, 8'h00);
        queue_beat(KIND_WRITE, REG_VADDR, 8'h3E);
        queue_beat(KIND_WRITE, REG_VADDR, 8'hFF);
        queue_beat(KIND_WRITE, REG_CONTROL, 8'h04);
        queue_beat(KIND_READ, REG_DATA, 8'h00);
        queue_beat(KIND_READ, REG_DATA, 8'h00);
        queue_beat(KIND_WRITE, REG_DATA, 8'hFF);
        queue_beat(KIND_WRITE, REG_SCROLL, 8'hFF);
        queue_beat(KIND_WRITE, REG_SCROLL, 8'h00);
        queue_beat(KIND_WRITE, REG_MASK, 8'hFF);
        queue_beat(KIND_WRITE, REG_STATUS, 8'h1F);
        queue_beat(KIND_WRITE, REG_OAM_ADDR, 8'hFF);
        queue_beat(KIND_WRITE, REG_OAM_DATA, 8'hAA);
        queue_beat(KIND_READ, REG_OAM_DATA, 8'h00);
        queue_beat(KIND_VBLANK_START, REG_CONTROL, 8'h00);
        queue_beat(KIND_WRITE, REG_CONTROL, 8'h80);
        queue_beat(KIND_VBLANK_START, REG_STATUS, 8'hFF);
        queue_beat(KIND_SPRITE_HIT, REG_DATA, 8'h00);
        queue_beat(KIND_READ, REG_STATUS, 8'h00);
        queue_beat(KIND_VBLANK_END, REG_MASK, 8'h00);
        for (int k = KIND_UNKNOWN_LOW; k <= KIND_UNKNOWN_HIGH; k++) begin
            queue_beat(3'(k), REG_DATA, 8'hFF);
        end
        while (beats_taken != beats_queued) @(posedge i_clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= 0;
                    long_stall_arm <= 1'b1;
                end
                1: begin
                    send_idle_pct <= IDLE_PCT_HEAVY;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct <= 0;
                    recv_stall_pct <= IDLE_PCT_HEAVY;
                end
                default: begin
                    send_idle_pct <= IDLE_PCT_LIGHT;
                    recv_stall_pct <= IDLE_PCT_LIGHT;
                end
            endcase
            phase_goal = beats_queued + BEATS_PER_PHASE;
            while (beats_queued < phase_goal) queue_random_sequence();
            while (beats_taken != beats_queued) @(posedge i_clk);
        end

        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
